FILE: rtl/smu_pkg.sv
`default_nettype none
package smu_pkg;

	// Ring geometry; the ring size is a power of two and a multiple of the bank count
	localparam int RING_SITES = 256;
	localparam int SITE_W     = $clog2(RING_SITES);
	localparam int BANKS      = 4;
	localparam int BANK_W     = $clog2(BANKS);
	localparam int ROWS       = RING_SITES / BANKS;
	localparam int ROW_W      = SITE_W - BANK_W;
	localparam int WIN        = 4;

	// Field widths
	localparam int OP_W      = 2;
	localparam int SITEF_W   = 8;
	localparam int H_W       = 16;
	localparam int E_W       = 24;
	localparam int RND_W     = 24;
	localparam int FRAC_W    = 24;
	localparam int W_W       = 32;
	localparam int DELTA_W   = H_W + 2;
	localparam int CFG_IDX_W = 3;

	localparam logic [W_W-1:0] ONE_Q24 = W_W'(1) << FRAC_W;
	localparam logic [H_W-1:0] H_MAX   = '1;

	// Operation codes
	localparam logic [OP_W-1:0] OP_GLAUBER  = 2'd0;
	localparam logic [OP_W-1:0] OP_KAWASAKI = 2'd1;
	localparam logic [OP_W-1:0] OP_LOAD     = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BOND_M4    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOND_M2    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOND_P2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOND_P4    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_UP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_DOWN = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_FWD  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_BWD  = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [SITEF_W-1:0] site;
		logic               step_up;
		logic               forward;
		logic [RND_W-1:0]   rand_fraction;
		logic [H_W-1:0]     load_value;
	} smu_in_t;

	typedef struct packed {
		logic           accepted;
		logic           overflow;
		logic [H_W-1:0] site_height;
		logic [E_W-1:0] bond_energy;
	} smu_out_t;

	typedef struct packed {
		logic [W_W-1:0] bond_m4;
		logic [W_W-1:0] bond_m2;
		logic [W_W-1:0] bond_p2;
		logic [W_W-1:0] bond_p4;
		logic [W_W-1:0] field_up;
		logic [W_W-1:0] field_down;
		logic [W_W-1:0] drive_fwd;
		logic [W_W-1:0] drive_bwd;
	} smu_weights_t;

	// Four consecutive heights around the site, lowest ring index first
	typedef logic [WIN-1:0][H_W-1:0] smu_win_t;

	// Decision for one word
	typedef struct packed {
		logic                      accepted;
		logic                      overflow;
		logic                      wr_x;
		logic                      wr_p;
		logic [H_W-1:0]            x_val;
		logic [H_W-1:0]            p_val;
		logic [H_W-1:0]            site_height;
		logic signed [DELTA_W-1:0] delta;
	} smu_eval_t;

endpackage
`default_nettype wire

FILE: rtl/smu_ram.sv
`default_nettype none
module smu_ram #(
	parameter int DATA_W = 16,
	parameter int DEPTH  = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DATA_W-1:0]        wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// One write, one registered read; a read of the address being written returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/smu_cfg.sv
`default_nettype none
module smu_cfg import smu_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [W_W-1:0]       cfg_data,
	output smu_weights_t              weights
);

	smu_weights_t weights_q;

	// Weight register file, all weights reset to 1.0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '{default: ONE_Q24};
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BOND_M4:    weights_q.bond_m4    <= cfg_data;
				REG_BOND_M2:    weights_q.bond_m2    <= cfg_data;
				REG_BOND_P2:    weights_q.bond_p2    <= cfg_data;
				REG_BOND_P4:    weights_q.bond_p4    <= cfg_data;
				REG_FIELD_UP:   weights_q.field_up   <= cfg_data;
				REG_FIELD_DOWN: weights_q.field_down <= cfg_data;
				REG_DRIVE_FWD:  weights_q.drive_fwd  <= cfg_data;
				REG_DRIVE_BWD:  weights_q.drive_bwd  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign weights = weights_q;

endmodule
`default_nettype wire

FILE: rtl/smu_eval.sv
`default_nettype none
module smu_eval import smu_pkg::*; (
	input  wire smu_in_t      item,
	input  wire smu_win_t     win,
	input  wire smu_weights_t weights,
	output smu_eval_t         res
);

	localparam logic signed [3:0] D_M4 = -4'sd4;
	localparam logic signed [3:0] D_M2 = -4'sd2;
	localparam logic signed [3:0] D_P2 = 4'sd2;
	localparam logic signed [3:0] D_P4 = 4'sd4;

	// Change of one bond when height h moves one unit up or down against neighbor n
	function automatic logic signed [3:0] bond_step(input logic [H_W-1:0] h,
			input logic [H_W-1:0] n, input logic up);
		logic signed [3:0] r;
		if (up) begin
			r = (h >= n) ? 4'sd1 : -4'sd1;
		end else begin
			r = (h > n) ? -4'sd1 : 4'sd1;
		end
		return r;
	endfunction

	function automatic logic [H_W-1:0] absdiff(input logic [H_W-1:0] a,
			input logic [H_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	logic                      rev;
	logic                      up;
	logic [H_W-1:0]            h_near, h_x, h_p, h_far;
	logic [H_W-1:0]            x_new, p_new;
	logic signed [H_W:0]       mid_diff;
	logic signed [3:0]         mid_step;
	logic signed [3:0]         d_g, d_k, d_sel;
	logic                      g_ovf, g_neg, k_ovf, k_neg;
	logic [W_W-1:0]            wb, ww;
	logic [2*W_W-1:0]          prod, lhs;
	logic                      draw;
	logic [H_W:0]              sum_new, sum_old;
	logic signed [DELTA_W-1:0] d_load;

	// Pick site, partner and outer neighbors out of the window
	always_comb begin
		rev    = (item.op == OP_KAWASAKI) && !item.forward;
		up     = item.step_up;
		h_near = rev ? win[3] : win[0];
		h_x    = rev ? win[2] : win[1];
		h_p    = rev ? win[1] : win[2];
		h_far  = rev ? win[0] : win[3];
		x_new  = up ? h_x + H_W'(1) : h_x - H_W'(1);
		p_new  = up ? h_p - H_W'(1) : h_p + H_W'(1);
	end

	// Bond energy change of a move
	always_comb begin
		mid_diff = $signed({1'b0, h_x}) - $signed({1'b0, h_p});
		if (up) begin
			if (mid_diff >= 0) mid_step = 4'sd2;
			else if (mid_diff == -1) mid_step = 4'sd0;
			else mid_step = -4'sd2;
		end else begin
			if (mid_diff <= 0) mid_step = 4'sd2;
			else if (mid_diff == 1) mid_step = 4'sd0;
			else mid_step = -4'sd2;
		end
		d_g   = bond_step(h_x, h_near, up) + bond_step(h_x, h_p, up);
		d_k   = bond_step(h_x, h_near, up) + mid_step + bond_step(h_p, h_far, !up);
		d_sel = (item.op == OP_KAWASAKI) ? d_k : d_g;
	end

	// Range checks
	always_comb begin
		g_ovf = up && (h_x == H_MAX);
		g_neg = !up && (h_x == '0);
		k_ovf = (up && (h_x == H_MAX)) || (!up && (h_p == H_MAX));
		k_neg = (up && (h_p == '0)) || (!up && (h_x == '0));
	end

	// Metropolis draw: rand * 2^24 < wb * ww
	always_comb begin
		case (d_sel)
			D_M4:    wb = weights.bond_m4;
			D_M2:    wb = weights.bond_m2;
			D_P2:    wb = weights.bond_p2;
			D_P4:    wb = weights.bond_p4;
			default: wb = ONE_Q24;
		endcase
		if (item.op == OP_KAWASAKI) begin
			ww = item.forward ? weights.drive_fwd : weights.drive_bwd;
		end else begin
			ww = up ? weights.field_up : weights.field_down;
		end
		prod = wb * ww;
		lhs  = (2*W_W)'({item.rand_fraction, {FRAC_W{1'b0}}});
		draw = lhs < prod;
	end

	// Exact energy correction of a load
	always_comb begin
		sum_new = (H_W+1)'(absdiff(item.load_value, h_near))
			+ (H_W+1)'(absdiff(item.load_value, h_p));
		sum_old = (H_W+1)'(absdiff(h_x, h_near)) + (H_W+1)'(absdiff(h_x, h_p));
		d_load  = $signed({1'b0, sum_new}) - $signed({1'b0, sum_old});
	end

	// Decision per operation
	always_comb begin
		res          = '0;
		res.x_val    = x_new;
		res.p_val    = p_new;
		case (item.op)
			OP_GLAUBER: begin
				res.overflow = g_ovf;
				res.accepted = !g_ovf && !g_neg && draw;
				res.wr_x     = res.accepted;
				res.delta    = res.accepted ? {{(DELTA_W-4){d_g[3]}}, d_g} : '0;
			end
			OP_KAWASAKI: begin
				res.overflow = k_ovf;
				res.accepted = !k_ovf && !k_neg && draw;
				res.wr_x     = res.accepted;
				res.wr_p     = res.accepted;
				res.delta    = res.accepted ? {{(DELTA_W-4){d_k[3]}}, d_k} : '0;
			end
			OP_LOAD: begin
				res.accepted = 1'b1;
				res.wr_x     = 1'b1;
				res.x_val    = item.load_value;
				res.delta    = d_load;
			end
			default: ;
		endcase
		res.site_height = res.wr_x ? res.x_val : h_x;
	end

endmodule
`default_nettype wire

FILE: rtl/sos_interface_metropolis_update.sv
// Metropolis update of a solid-on-solid interface on a ring of RING_SITES heights, with the
// running bond energy kept beside it. Words are Glauber moves, Kawasaki moves or height
// loads; each gives one result word with the accept and overflow flags, the height at the
// site afterwards and the bond energy afterwards. The block takes one word per cycle while
// the output is not stalled; the banked height read is done at the accepting edge, and
// evaluation goes straight into the output register. The heights live in four RAM banks by
// ring index modulo four, so the four neighboring heights of a move come out in one read;
// the write-back of a word is forwarded to the word right behind it. Heights read as zero
// after reset through per-site valid flags, so no clearing pass is needed. Weights
// are Q8.24, to be written by the user only while the block is idle (not enforced here).
`default_nettype none
module sos_interface_metropolis_update import smu_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [W_W-1:0]       cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire smu_in_t              in_word,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output smu_out_t                  out_word
);

	smu_weights_t weights;

	smu_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.weights   (weights)
	);

	logic                  in_fire, s1_adv, s1_fire;
	logic [SITE_W-1:0]     x0, base0;
	logic                  rev0;
	logic [ROW_W-1:0]      bank_raddr [BANKS];
	logic [H_W-1:0]        bank_rdata [BANKS];
	logic                  bank_we    [BANKS];
	logic [ROW_W-1:0]      bank_waddr [BANKS];
	logic [H_W-1:0]        bank_wdata [BANKS];

	logic                  s1_valid_q;
	smu_in_t               item_s1;
	logic [SITE_W-1:0]     base_s1;
	logic [WIN-1:0]        vld_s1;
	logic [RING_SITES-1:0] valid_q;

	logic                  fwd_x_en_q, fwd_p_en_q;
	logic [SITE_W-1:0]     fwd_x_addr_q, fwd_p_addr_q;
	logic [H_W-1:0]        fwd_x_data_q, fwd_p_data_q;

	smu_win_t              win;
	smu_eval_t             ev;
	logic [SITE_W-1:0]     x_s1, p_s1;
	logic                  wr_x_go, wr_p_go;
	logic [E_W-1:0]        energy_q, energy_next;

	logic                  out_valid_q;
	smu_out_t              out_word_q;

	// Handshake
	assign s1_adv   = !out_valid_q || out_ready;
	assign s1_fire  = s1_valid_q && s1_adv;
	assign in_ready = !s1_valid_q || s1_adv;
	assign in_fire  = in_valid && in_ready;

	// Read window: four consecutive sites starting one or two below the site
	always_comb begin
		x0    = SITE_W'(in_word.site);
		rev0  = (in_word.op == OP_KAWASAKI) && !in_word.forward;
		base0 = rev0 ? x0 - SITE_W'(2) : x0 - SITE_W'(1);
	end

	// Height banks
	for (genvar k = 0; k < BANKS; k++) begin : g_bank
		logic [BANK_W-1:0] off;
		logic [SITE_W-1:0] rd_site;

		assign off           = BANK_W'(k) - base0[BANK_W-1:0];
		assign rd_site       = base0 + SITE_W'(off);
		assign bank_raddr[k] = rd_site[SITE_W-1:BANK_W];

		assign bank_we[k] = (wr_x_go && (x_s1[BANK_W-1:0] == BANK_W'(k)))
			|| (wr_p_go && (p_s1[BANK_W-1:0] == BANK_W'(k)));
		assign bank_waddr[k] = (wr_x_go && (x_s1[BANK_W-1:0] == BANK_W'(k)))
			? x_s1[SITE_W-1:BANK_W] : p_s1[SITE_W-1:BANK_W];
		assign bank_wdata[k] = (wr_x_go && (x_s1[BANK_W-1:0] == BANK_W'(k)))
			? ev.x_val : ev.p_val;

		smu_ram #(
			.DATA_W (H_W),
			.DEPTH  (ROWS)
		) u_ram (
			.clk   (clk),
			.we    (bank_we[k]),
			.waddr (bank_waddr[k]),
			.wdata (bank_wdata[k]),
			.re    (in_fire),
			.raddr (bank_raddr[k]),
			.rdata (bank_rdata[k])
		);
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_ready) begin
			s1_valid_q <= in_valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_word;
			base_s1 <= base0;
			for (int j = 0; j < WIN; j++) begin
				vld_s1[j] <= valid_q[base0 + SITE_W'(j)];
			end
		end
	end

	// Unwritten sites read as zero; the last write-back overrides the RAM output
	always_comb begin
		for (int j = 0; j < WIN; j++) begin
			logic [SITE_W-1:0] w;
			w      = base_s1 + SITE_W'(j);
			win[j] = vld_s1[j] ? bank_rdata[w[BANK_W-1:0]] : '0;
			if (fwd_x_en_q && (fwd_x_addr_q == w)) begin
				win[j] = fwd_x_data_q;
			end
			if (fwd_p_en_q && (fwd_p_addr_q == w)) begin
				win[j] = fwd_p_data_q;
			end
		end
	end

	smu_eval u_eval (
		.item    (item_s1),
		.win     (win),
		.weights (weights),
		.res     (ev)
	);

	// Write-back addresses
	always_comb begin
		x_s1        = SITE_W'(item_s1.site);
		p_s1        = item_s1.forward ? x_s1 + SITE_W'(1) : x_s1 - SITE_W'(1);
		wr_x_go     = s1_fire && ev.wr_x;
		wr_p_go     = s1_fire && ev.wr_p;
		energy_next = energy_q + E_W'(ev.delta);
	end

	// Per-site valid flags, forwarding enables, energy and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			fwd_x_en_q  <= 1'b0;
			fwd_p_en_q  <= 1'b0;
			energy_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_x_go) valid_q[x_s1] <= 1'b1;
			if (wr_p_go) valid_q[p_s1] <= 1'b1;
			if (s1_fire) begin
				fwd_x_en_q <= ev.wr_x;
				fwd_p_en_q <= ev.wr_p;
				energy_q   <= energy_next;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Forwarding data and result word
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			fwd_x_addr_q           <= x_s1;
			fwd_x_data_q           <= ev.x_val;
			fwd_p_addr_q           <= p_s1;
			fwd_p_data_q           <= ev.p_val;
			out_word_q.accepted    <= ev.accepted;
			out_word_q.overflow    <= ev.overflow;
			out_word_q.site_height <= ev.site_height;
			out_word_q.bond_energy <= energy_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
`default_nettype wire

FILE: rtl/smu_checker.sv
`default_nettype none
module smu_checker import smu_pkg::*; (
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     in_ready,
	input wire logic     out_valid,
	input wire logic     out_ready,
	input wire smu_out_t out_word
);

	// A stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// An overflow is always a rejection
	a_ovf_reject: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.overflow |-> !out_word.accepted)
		else $error("overflow flagged on an accepted move");

	// Sum of height differences around a ring is even
	a_energy_even: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !out_word.bond_energy[0])
		else $error("odd bond energy");

	// With the output empty the input side is never blocked
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind sos_interface_metropolis_update smu_checker u_smu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
`default_nettype wire
